FILE: sv/plar_pkg.sv
// package for the packet link with ack and retransmit
// holds sizes, codes and the crc step function; no dependencies
package plar_pkg;
  localparam int PAYLOAD_BYTES = 16;
  localparam int RING_DEPTH = 16;
  localparam int FRAME_BYTES = PAYLOAD_BYTES + 2;
  localparam int BODY_BYTES = PAYLOAD_BYTES + 1;
  localparam int RIDX_W = $clog2(RING_DEPTH);
  localparam int FIDX_W = $clog2(FRAME_BYTES);
  localparam int RING_WORDS = RING_DEPTH * FRAME_BYTES;
  localparam int RADDR_W = $clog2(RING_WORDS);
  localparam logic [7:0] FILL_BYTE = 8'hFF;
  localparam logic [7:0] CTRL_LEN = 8'h01;

  localparam logic [7:0] RESET_POLY = 8'h07;
  localparam logic [7:0] RESET_INIT = 8'h00;
  localparam logic [7:0] RESET_ACK = 8'd21;

  localparam logic [1:0] FUNC_RX = 2'd0;
  localparam logic [1:0] FUNC_POP = 2'd1;
  localparam logic [1:0] FUNC_TX = 2'd2;
  localparam logic [1:0] KIND_LINE = 2'd0;
  localparam logic [1:0] KIND_POP = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic [1:0] REG_POLY = 2'd0;
  localparam logic [1:0] REG_INIT = 2'd1;
  localparam logic [1:0] REG_ACK = 2'd2;
  localparam logic [1:0] REG_RTX = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CTRL, ST_REPLAY, ST_POP, ST_POPWAIT, ST_STORE
  } state_t;

  // source of an emitted frame
  typedef enum logic [1:0] {SRC_CTRL, SRC_REPLAY, SRC_RING} src_t;

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b,
                                          input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // crc of a control frame body
  function automatic logic [7:0] control_crc(input logic [7:0] code, input logic [7:0] init,
                                             input logic [7:0] poly);
    logic [7:0] c;
    c = crc_step(init, CTRL_LEN, poly);
    c = crc_step(c, code, poly);
    for (int i = 2; i < BODY_BYTES; i++) c = crc_step(c, FILL_BYTE, poly);
    return c;
  endfunction

  localparam logic [7:0] RESET_ACK_CRC = control_crc(RESET_ACK, RESET_INIT, RESET_POLY);
endpackage

FILE: sv/plar_if.sv
// handshake channels for the link block
// depends on nothing
interface plar_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [1:0] func;
  logic [7:0] byte_value;
  modport source (output valid, func, byte_value, input ready);
  modport sink (input valid, func, byte_value, output ready);
endinterface

interface plar_out_if (input logic clk);
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic last_of_run;
  logic frames_available;
  logic dropped_oldest;
  modport source (output valid, kind, data_byte, last_of_run, frames_available,
                  dropped_oldest, input ready);
  modport sink (input valid, kind, data_byte, last_of_run, frames_available,
                dropped_oldest, output ready);
endinterface

FILE: sv/plar_ram.sv
// generic simple dual port synchronous ram (one write port, one read port), registered read
// no dependencies
module plar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/packet_link_ack_retransmit.sv
// packet link with crc-8 framing, ack and retransmit; uses plar_pkg, plar_if, plar_ram
// a transmit byte or an empty pop is answered in the cycle after the transfer;
// a retransmit or replay streams 18 bytes after the crc byte, one per cycle unless
// the output stalls, a pop too after a ring read wait state; a stored frame is copied
// into the ring memory before its ack. items are taken one at a time after each run.
// reset is synchronous; the replay buffer then holds the ack frame of the reset registers.
module packet_link_ack_retransmit (
  input  logic        clk,
  input  logic        rst,
  plar_in_if.sink     in_ch,
  plar_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import plar_pkg::*;

  logic [7:0] poly, cinit, ack_c, rtx_c;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= 8'd7; cinit <= 8'd0; ack_c <= 8'd21; rtx_c <= 8'd25;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_POLY: poly <= pwdata[7:0];
        REG_INIT: cinit <= pwdata[7:0];
        REG_ACK:  ack_c <= pwdata[7:0];
        REG_RTX:  rtx_c <= pwdata[7:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      REG_POLY: prdata = {24'd0, poly};
      REG_INIT: prdata = {24'd0, cinit};
      REG_ACK:  prdata = {24'd0, ack_c};
      default:  prdata = {24'd0, rtx_c};
    endcase
  end

  state_t state, state_next;
  logic [7:0] rx_buf [BODY_BYTES];
  logic [7:0] tx_buf [FRAME_BYTES];
  logic [7:0] rp_buf [FRAME_BYTES];
  logic [1:0] rx_phase;
  logic [FIDX_W-1:0] rx_cnt, tx_cnt, pos;
  logic [7:0] rx_crc;
  logic [RIDX_W-1:0] rd_idx, wr_idx;
  logic rx_ctrl_rtx, rx_ctrl_ack, tx_ctrl_rtx, tx_ctrl_ack;
  logic [7:0] ctrl_code, ctrl_crc, crc_b, last_crc;
  logic avail, drop;
  logic [7:0] lb;

  // ring memory
  logic ram_we;
  logic [RADDR_W-1:0] ram_wa, ram_ra, base_rd, base_wr;
  logic [7:0] ram_wd, ram_rd;
  assign base_rd = RADDR_W'(rd_idx * FRAME_BYTES);
  assign base_wr = RADDR_W'(wr_idx * FRAME_BYTES);
  plar_ram #(.WIDTH(8), .DEPTH(RING_WORDS)) u_ring (
    .clk, .we(ram_we), .waddr(ram_wa), .wdata(ram_wd), .raddr(ram_ra), .rdata(ram_rd));

  // rx and tx frame control check
  always_comb begin
    logic fill_r, fill_t;
    fill_r = 1'b1; fill_t = 1'b1;
    for (int i = 2; i < BODY_BYTES; i++) begin
      if (rx_buf[i] != FILL_BYTE) fill_r = 1'b0;
      if (tx_buf[i] != FILL_BYTE) fill_t = 1'b0;
    end
    rx_ctrl_rtx = fill_r && rx_buf[0] == CTRL_LEN && rx_buf[1] == rtx_c;
    rx_ctrl_ack = fill_r && rx_buf[0] == CTRL_LEN && rx_buf[1] == ack_c;
    tx_ctrl_rtx = fill_t && tx_buf[0] == CTRL_LEN && tx_buf[1] == rtx_c;
    tx_ctrl_ack = fill_t && tx_buf[0] == CTRL_LEN && tx_buf[1] == ack_c;
  end

  // control frame byte at pos, crc built serially alongside
  logic [7:0] cbyte;
  always_comb begin
    if (pos == '0) cbyte = CTRL_LEN;
    else if (pos == FIDX_W'(1)) cbyte = ctrl_code;
    else if (pos == FIDX_W'(FRAME_BYTES - 1)) cbyte = ctrl_crc;
    else cbyte = FILL_BYTE;
  end

  // output register
  logic ov, ob_free;
  logic [1:0] ok; logic [7:0] od; logic ol, oa, odp;
  assign out_ch.valid = ov; assign out_ch.kind = ok; assign out_ch.data_byte = od;
  assign out_ch.last_of_run = ol; assign out_ch.frames_available = oa;
  assign out_ch.dropped_oldest = odp;
  assign ob_free = !ov || out_ch.ready;
  assign in_ch.ready = (state == ST_IDLE) && ob_free;
  logic acc;
  assign acc = in_ch.valid && in_ch.ready;
  logic pos_last;
  assign pos_last = pos == FIDX_W'(FRAME_BYTES - 1);
  logic pop_first;

  always_comb begin
    state_next = state;
    ram_we = 1'b0; ram_wa = base_wr + RADDR_W'(pos);
    ram_wd = (pos == FIDX_W'(BODY_BYTES)) ? last_crc : rx_buf[pos];
    ram_ra = base_rd + RADDR_W'(pos);
    unique case (state)
      ST_IDLE: ;
      ST_CTRL:   if (ob_free && pos_last) state_next = ST_IDLE;
      ST_REPLAY: if (ob_free && pos_last) state_next = ST_IDLE;
      ST_POPWAIT: state_next = ST_POP;
      ST_POP: begin
        if (ob_free) begin
          ram_ra = base_rd + RADDR_W'(pos) + RADDR_W'(1);
          if (pos_last) state_next = ST_IDLE;
        end
      end
      ST_STORE: begin
        ram_we = 1'b1;
        if (pos_last) state_next = ST_CTRL;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign crc_b = crc_step(rx_crc, in_ch.byte_value, poly);
  assign lb = in_ch.byte_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; ov <= 1'b0; rx_phase <= 2'd0; rx_cnt <= '0; tx_cnt <= '0;
      rd_idx <= '0; wr_idx <= '0; pos <= '0; rx_crc <= 8'd0; pop_first <= 1'b0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        rp_buf[i] <= (i == 0) ? CTRL_LEN : (i == 1) ? RESET_ACK :
                     (i == BODY_BYTES) ? RESET_ACK_CRC : FILL_BYTE;
      end
    end else begin
      state <= state_next;
      if (out_ch.ready) ov <= 1'b0;
      if (acc) begin
        pos <= '0;
        unique case (in_ch.func)
          FUNC_RX: begin
            if (rx_phase == 2'd0) begin
              rx_buf[0] <= lb; rx_crc <= crc_step(cinit, lb, poly);
              rx_cnt <= '0; rx_phase <= 2'd1;
            end else if (rx_phase == 2'd1) begin
              rx_buf[rx_cnt + FIDX_W'(1)] <= lb; rx_crc <= crc_b;
              rx_cnt <= rx_cnt + FIDX_W'(1);
              if (rx_cnt == FIDX_W'(PAYLOAD_BYTES - 1)) rx_phase <= 2'd2;
            end else begin
              rx_phase <= 2'd0; rx_cnt <= '0;
              avail <= rd_idx != wr_idx; drop <= 1'b0; last_crc <= lb;
              ctrl_crc <= cinit;
              if (lb != rx_crc) begin
                ctrl_code <= rtx_c; state <= ST_CTRL;
              end else if (rx_ctrl_rtx) begin
                state <= ST_REPLAY;
              end else if (!rx_ctrl_ack) begin
                ctrl_code <= ack_c; avail <= 1'b1; state <= ST_STORE;
                if (wr_idx + RIDX_W'(1) == rd_idx) begin
                  rd_idx <= rd_idx + RIDX_W'(1); drop <= 1'b1;
                end
              end
            end
          end
          FUNC_POP: begin
            if (rd_idx == wr_idx) begin
              ov <= 1'b1; ok <= KIND_EMPTY; od <= 8'd0; ol <= 1'b1; oa <= 1'b0; odp <= 1'b0;
            end else begin
              state <= ST_POPWAIT; avail <= (rd_idx + RIDX_W'(1)) != wr_idx;
            end
          end
          FUNC_TX: begin
            tx_buf[tx_cnt] <= lb;
            ov <= 1'b1; ok <= KIND_LINE; od <= lb; ol <= 1'b1; oa <= rd_idx != wr_idx;
            odp <= 1'b0;
            if (tx_cnt == FIDX_W'(FRAME_BYTES - 1)) begin
              tx_cnt <= '0; pop_first <= 1'b1;
            end else tx_cnt <= tx_cnt + FIDX_W'(1);
          end
          default: ;
        endcase
      end
      // replay capture in the cycle after the last transmit byte lands
      if (pop_first) begin
        pop_first <= 1'b0;
        if (!tx_ctrl_rtx && !tx_ctrl_ack) begin
          for (int i = 0; i < FRAME_BYTES; i++) rp_buf[i] <= tx_buf[i];
        end
      end
      if (state == ST_STORE) begin
        pos <= pos_last ? '0 : pos + FIDX_W'(1);
        if (pos_last) wr_idx <= wr_idx + RIDX_W'(1);
      end
      if ((state == ST_CTRL || state == ST_REPLAY) && ob_free) begin
        ov <= 1'b1; ok <= KIND_LINE; ol <= pos_last; oa <= avail; odp <= drop;
        od <= (state == ST_CTRL) ? cbyte : rp_buf[pos];
        if (pos != FIDX_W'(FRAME_BYTES - 1)) ctrl_crc <= crc_step(ctrl_crc, cbyte, poly);
        pos <= pos_last ? '0 : pos + FIDX_W'(1);
      end
      if (state == ST_POPWAIT) pos <= '0;
      if (state == ST_POP && ob_free) begin
        ov <= 1'b1; ok <= KIND_POP; od <= ram_rd; ol <= pos_last; oa <= avail; odp <= 1'b0;
        pos <= pos_last ? '0 : pos + FIDX_W'(1);
        if (pos_last) rd_idx <= rd_idx + RIDX_W'(1);
      end
    end
  end

  // pop read must pause while output stalls: hold ram address by rereading
  // (handled since ram_ra keeps pos when stalled)

  assert property (@(posedge clk) disable iff (rst) (state != ST_IDLE) |-> !in_ch.ready)
    else $error("input taken during a frame run");
  assert property (@(posedge clk) disable iff (rst)
    (ov && out_ch.ready && ol && state == ST_IDLE) |=> !ov || $past(acc))
    else $error("result after end of run");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_STORE && pos_last) |=> wr_idx == $past(wr_idx) + RIDX_W'(1))
    else $error("ring write index not advanced");
endmodule

FILE: bench/plar_checker.sv
// watches both channels and the register port of the link block, predicts its results
// and compares them in order; depends on plar_pkg and the channel interfaces in plar_if
module plar_checker (
  input  logic        clk,
  input  logic        rst,
  plar_in_if          in_ch,
  plar_out_if         out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import plar_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic       avail;
    logic       drop;
  } link_result_t;

  typedef logic [7:0] frame_t [FRAME_BYTES];

  link_result_t link_q[$];

  logic [7:0] poly, crc_init, ack_code, rtx_code;
  logic [1:0] rx_phase;
  int         rx_count;
  logic [7:0] rx_crc;
  frame_t     rx_body;
  frame_t     ring_mem [RING_DEPTH];
  int         rd_idx, wr_idx;
  frame_t     replay_frame;
  frame_t     tx_stage;
  int         tx_count;
  int         mismatches;

  initial errors = 0;
  initial pending = 0;
  initial mismatches = 0;

  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    return c;
  endfunction

  function automatic frame_t control_frame(input logic [7:0] code);
    frame_t f;
    logic [7:0] c;
    c = crc_init;
    f[0] = CTRL_LEN;
    f[1] = code;
    for (int i = 2; i < BODY_BYTES; i++) f[i] = FILL_BYTE;
    for (int i = 0; i < BODY_BYTES; i++) c = crc_fold(c, f[i]);
    f[BODY_BYTES] = c;
    return f;
  endfunction

  // crc byte is not looked at
  function automatic bit is_control(input frame_t f, input logic [7:0] code);
    if (f[0] != CTRL_LEN || f[1] != code) return 0;
    for (int i = 2; i < BODY_BYTES; i++) if (f[i] != FILL_BYTE) return 0;
    return 1;
  endfunction

  function automatic void push_frame(input logic [1:0] kind, input frame_t f,
                                     input logic avail, input logic drop);
    link_result_t r;
    for (int k = 0; k < FRAME_BYTES; k++) begin
      r.kind = kind;
      r.data = f[k];
      r.last = (k == FRAME_BYTES - 1);
      r.avail = avail;
      r.drop = drop;
      link_q.push_back(r);
    end
  endfunction

  function automatic void push_one(input logic [1:0] kind, input logic [7:0] b,
                                   input logic avail);
    link_result_t r;
    r.kind = kind;
    r.data = b;
    r.last = 1'b1;
    r.avail = avail;
    r.drop = 1'b0;
    link_q.push_back(r);
  endfunction

  function automatic void clear_state();
    poly = 8'd7;
    crc_init = 8'd0;
    ack_code = 8'd21;
    rtx_code = 8'd25;
    rx_phase = 2'd0;
    rx_count = 0;
    rx_crc = crc_init;
    rd_idx = 0;
    wr_idx = 0;
    tx_count = 0;
    replay_frame = control_frame(ack_code);
    link_q.delete();
  endfunction

  function automatic void predict(input logic [1:0] func, input logic [7:0] b);
    logic avail;
    int nxt;
    logic drop;
    avail = (rd_idx != wr_idx);
    case (func)
      FUNC_RX: begin
        if (rx_phase == 2'd0) begin
          rx_body[0] = b;
          rx_crc = crc_fold(crc_init, b);
          rx_count = 0;
          rx_phase = 2'd1;
        end else if (rx_phase == 2'd1) begin
          rx_body[1 + rx_count] = b;
          rx_crc = crc_fold(rx_crc, b);
          rx_count++;
          if (rx_count >= PAYLOAD_BYTES) rx_phase = 2'd2;
        end else begin
          rx_phase = 2'd0;
          rx_count = 0;
          if (b != rx_crc) begin
            push_frame(KIND_LINE, control_frame(rtx_code), avail, 1'b0);
          end else if (is_control(rx_body, rtx_code)) begin
            push_frame(KIND_LINE, replay_frame, avail, 1'b0);
          end else if (!is_control(rx_body, ack_code)) begin
            nxt = (wr_idx + 1) % RING_DEPTH;
            drop = 1'b0;
            // full ring loses its oldest frame
            if (nxt == rd_idx) begin
              rd_idx = (rd_idx + 1) % RING_DEPTH;
              drop = 1'b1;
            end
            ring_mem[wr_idx] = rx_body;
            ring_mem[wr_idx][BODY_BYTES] = b;
            wr_idx = nxt;
            push_frame(KIND_LINE, control_frame(ack_code), 1'b1, drop);
          end
        end
      end
      FUNC_POP: begin
        if (!avail) begin
          push_one(KIND_EMPTY, 8'd0, 1'b0);
        end else begin
          nxt = rd_idx;
          rd_idx = (rd_idx + 1) % RING_DEPTH;
          push_frame(KIND_POP, ring_mem[nxt], rd_idx != wr_idx, 1'b0);
        end
      end
      FUNC_TX: begin
        tx_stage[tx_count] = b;
        tx_count++;
        if (tx_count >= FRAME_BYTES) begin
          tx_count = 0;
          if (!is_control(tx_stage, rtx_code) && !is_control(tx_stage, ack_code))
            replay_frame = tx_stage;
        end
        push_one(KIND_LINE, b, avail);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    link_result_t want;
    link_result_t got;
    if (rst) begin
      clear_state();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_POLY: poly = pwdata[7:0];
          REG_INIT: crc_init = pwdata[7:0];
          REG_ACK:  ack_code = pwdata[7:0];
          REG_RTX:  rtx_code = pwdata[7:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.kind, out_ch.data_byte, out_ch.last_of_run,
                out_ch.frames_available, out_ch.dropped_oldest};
        if (link_q.size() == 0) begin
          errors <= errors + 1;
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = link_q.pop_front();
          if (got !== want) begin
            errors <= errors + 1;
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) predict(in_ch.func, in_ch.byte_value);
    end
    pending <= link_q.size();
  end
endmodule

FILE: bench/packet_link_ack_retransmit_test.sv
// top of the link bench: clock, reset, register writes and frame stimulus
// depends on plar_pkg, plar_if, the block itself and plar_checker
module packet_link_ack_retransmit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import plar_pkg::*;

  localparam int IDLE_LIMIT = 3000;

  typedef logic [7:0] frame_t [FRAME_BYTES];

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic [1:0] src_func = FUNC_RX;
  logic [7:0] src_byte = 8'd0;
  logic sink_ready = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic pready;
  int errors, pending;
  int idle_cycles = 0;
  int cyc = 0;
  int burst_left = 0;
  int items_sent = 0;
  logic [7:0] poly, crc_init, ack_code, rtx_code;

  plar_in_if in_ch (clk);
  plar_out_if out_ch (clk);

  assign in_ch.valid = src_valid;
  assign in_ch.func = src_func;
  assign in_ch.byte_value = src_byte;
  assign out_ch.ready = sink_ready;

  packet_link_ack_retransmit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  plar_checker u_checker (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver stall pattern changes with bits 8:7 of the cycle counter
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst) sink_ready <= 1'b0;
    else case (cyc[8:7])
      2'd0: sink_ready <= 1'b1;
      2'd1: sink_ready <= ($urandom_range(0, 3) != 0);
      2'd2: sink_ready <= ($urandom_range(0, 3) == 0);
      default: sink_ready <= cyc[2];
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((src_valid && in_ch.ready) || (out_ch.valid && sink_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic frame_t seal(input frame_t f);
    logic [7:0] c;
    c = crc_init;
    for (int i = 0; i < BODY_BYTES; i++) begin
      c = c ^ f[i];
      for (int j = 0; j < 8; j++) c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    end
    f[BODY_BYTES] = c;
    return f;
  endfunction

  function automatic frame_t control(input logic [7:0] code);
    frame_t f;
    f[0] = CTRL_LEN;
    f[1] = code;
    for (int i = 2; i < FRAME_BYTES; i++) f[i] = FILL_BYTE;
    return seal(f);
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    f[0] = ($urandom_range(0, 3) == 0) ? CTRL_LEN : 8'($urandom);
    for (int i = 1; i < FRAME_BYTES; i++) f[i] = 8'($urandom);
    return seal(f);
  endfunction

  task automatic reg_write(input logic [1:0] idx, input logic [7:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_POLY: poly = v;
      REG_INIT: crc_init = v;
      REG_ACK:  ack_code = v;
      default:  rtx_code = v;
    endcase
  endtask

  task automatic drain();
    src_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] p, input logic [7:0] i,
                          input logic [7:0] a, input logic [7:0] r);
    drain();
    reg_write(REG_POLY, p);
    reg_write(REG_INIT, i);
    reg_write(REG_ACK, a);
    reg_write(REG_RTX, r);
  endtask

  task automatic send_item(input logic [1:0] f, input logic [7:0] b);
    int gap;
    src_valid <= 1'b1;
    src_func <= f;
    src_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (f != 2'd3) items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        src_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic send_frame(input logic [1:0] f, input frame_t fr);
    for (int i = 0; i < FRAME_BYTES; i++) send_item(f, fr[i]);
  endtask

  task automatic random_traffic(input int count);
    frame_t fr;
    int pick;
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        fr = random_frame();
        // corrupt the crc now and then
        if ($urandom_range(0, 6) == 0) fr[BODY_BYTES] ^= 8'(1 << $urandom_range(0, 7));
        send_frame(FUNC_RX, fr);
      end else if (pick < 50) begin
        send_frame(FUNC_RX, control(rtx_code));
      end else if (pick < 59) begin
        send_frame(FUNC_RX, control(ack_code));
      end else if (pick < 65) begin
        for (int i = 0; i < FRAME_BYTES; i++) fr[i] = 8'($urandom);
        send_frame(FUNC_RX, fr);
      end else if (pick < 80) begin
        send_item(FUNC_POP, 8'($urandom));
      end else if (pick < 96) begin
        case ($urandom_range(0, 2))
          0: fr = random_frame();
          1: fr = control(rtx_code);
          default: fr = control(ack_code);
        endcase
        send_frame(FUNC_TX, fr);
      end else begin
        send_item(2'd3, 8'($urandom));
      end
    end
  endtask

  initial begin
    frame_t fr;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 24);
    set_regs(8'd7, 8'd0, 8'd21, 8'd25);

    // empty pop, ignored function, then one stored frame with extreme bytes and its pop
    send_item(FUNC_POP, 8'hFF);
    send_item(2'd3, 8'hFF);
    fr[0] = 8'hFF;
    for (int i = 1; i < BODY_BYTES; i++) fr[i] = (i % 2) ? 8'h00 : 8'hFF;
    send_frame(FUNC_RX, seal(fr));
    send_item(FUNC_POP, 8'h00);

    random_traffic(85);
    set_regs(8'h00, 8'hFF, 8'h00, 8'hFF);
    random_traffic(85);
    set_regs(8'hFF, 8'h00, 8'hFF, 8'h00);
    random_traffic(85);
    set_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    random_traffic(85);

    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
sv/plar_pkg.sv
sv/plar_if.sv
sv/plar_ram.sv
sv/packet_link_ack_retransmit.sv
bench/plar_checker.sv
bench/packet_link_ack_retransmit_test.sv
